@@ rtl/core/r2fft_pkg.sv @@
// ============================================================================
// r2fft_pkg
// Shared constants, types and elaboration-time twiddle table for the
// radix-2 frame FFT.
// ============================================================================
package r2fft_pkg;

    localparam int POINTS      = 128;
    localparam int SAMPLE_BITS = 16;
    localparam int OUT_BITS    = 24;
    localparam int TW_BITS     = 18;
    localparam int TW_FRAC     = 16;

    localparam int LG      = $clog2(POINTS);
    localparam int SW      = $clog2(LG);
    // working word: sample width plus one bit of growth per stage plus rotation headroom
    localparam int W       = SAMPLE_BITS + LG + 1;
    localparam int IN_WIDTH   = 2 * SAMPLE_BITS;
    localparam int WORK_WIDTH = 2 * W;
    localparam int HALF    = POINTS / 2;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic [2*TW_BITS-1:0] tw_word_t;
    typedef tw_word_t tw_table_t [HALF];

    // butterfly unit strobes
    typedef struct packed {
        logic cap_a;
        logic mul;
        logic rnd;
    } bfly_ctl_t;

    // divide by a small fixed count, one literal per arm
    function automatic logic [63:0] div_small(logic [63:0] v, int unsigned n);
        logic [63:0] r;
        case (n)
            1:  r = v;
            2:  r = v / 2;
            3:  r = v / 3;
            4:  r = v / 4;
            5:  r = v / 5;
            6:  r = v / 6;
            7:  r = v / 7;
            8:  r = v / 8;
            9:  r = v / 9;
            10: r = v / 10;
            11: r = v / 11;
            12: r = v / 12;
            13: r = v / 13;
            14: r = v / 14;
            15: r = v / 15;
            16: r = v / 16;
            17: r = v / 17;
            18: r = v / 18;
            19: r = v / 19;
            20: r = v / 20;
            21: r = v / 21;
            22: r = v / 22;
            23: r = v / 23;
            24: r = v / 24;
            25: r = v / 25;
            26: r = v / 26;
            default: r = v;
        endcase
        return r;
    endfunction

    // cos/sin of 2*pi*k/POINTS over a quarter wave, Taylor in Q30, rounded to Q2.16
    function automatic tw_word_t quarter_wave(int unsigned k);
        logic [63:0]  theta;
        logic [63:0]  term;
        longint       ca;
        longint       sa;
        logic [63:0]  cr;
        logic [63:0]  sr;
        theta = (PI_Q30 * 64'd2 * 64'(k)) >> LG;
        term  = 64'd1 << 30;
        ca    = longint'(term);
        sa    = 0;
        for (int unsigned n = 1; n <= 26; n++)
        begin
            term = div_small((term * theta) >> 30, n);
            case (n & 3)
                1:       sa = sa + longint'(term);
                2:       ca = ca - longint'(term);
                3:       sa = sa - longint'(term);
                default: ca = ca + longint'(term);
            endcase
        end
        if (ca < 0)
            ca = 0;
        if (sa < 0)
            sa = 0;
        cr = (64'(ca) + 64'd8192) >> 14;
        sr = (64'(sa) + 64'd8192) >> 14;
        // packed as {sin, cos}
        return {sr[TW_BITS-1:0], cr[TW_BITS-1:0]};
    endfunction

    // W^k = exp(-j*2*pi*k/POINTS), entry packed as {im, re}
    function automatic tw_table_t build_tw();
        tw_table_t     t;
        tw_word_t      q;
        logic [TW_BITS-1:0] c;
        logic [TW_BITS-1:0] s;
        for (int unsigned k = 0; k < HALF; k++)
        begin
            if (k <= POINTS / 4)
            begin
                q = quarter_wave(k);
                c = q[TW_BITS-1:0];
                s = q[2*TW_BITS-1:TW_BITS];
                t[k] = {TW_BITS'(-s), c};
            end
            else
            begin
                q = quarter_wave(k - POINTS / 4);
                c = q[TW_BITS-1:0];
                s = q[2*TW_BITS-1:TW_BITS];
                t[k] = {TW_BITS'(-c), TW_BITS'(-s)};
            end
        end
        return t;
    endfunction

    localparam tw_table_t TW_TABLE = build_tw();

    // clamp a working value into the output field
    function automatic logic [OUT_BITS-1:0] sat_out(logic signed [W-1:0] v);
        longint x;
        longint hi;
        x  = longint'(v);
        hi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
        if (x > hi)
            x = hi;
        else if (x < -hi - 1)
            x = -hi - 1;
        return x[OUT_BITS-1:0];
    endfunction

    // reverse the index bits
    function automatic logic [LG-1:0] bit_rev(logic [LG-1:0] v);
        logic [LG-1:0] r;
        for (int b = 0; b < LG; b++)
            r[LG-1-b] = v[b];
        return r;
    endfunction

endpackage

@@ rtl/core/radix2_fft_frame.sv @@
// ============================================================================
// radix2_fft_frame
// 128-point radix-2 decimation-in-time FFT over frames of streamed samples.
// ============================================================================
// Each sample transfer returns one bin of the previous frame, in natural
// order; bin_valid (tuser) is low and the bin is zero until the first frame
// has been transformed. While collecting, the input is not ready again until
// the work RAM read that fetches the bin for the last sample has completed.
// After the last sample of a frame the input stalls while the transform
// runs: a bit-reversed copy from the sample RAM into the work RAM, then 448
// butterflies, each stepping through read A, read B, multiply, round, write A
// and write B, as set by the single read and write port of the work RAM.
// ============================================================================
module radix2_fft_frame (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_re[15:0], sample_im[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // bin_re[23:0], bin_im[47:24], bin_index[54:48], 0
    output logic        m_axis_tuser,   // bin_valid
    output logic        m_axis_tlast    // frame_last
);
    import r2fft_pkg::*;

    typedef enum logic [7:0] {
        ST_COLLECT = 8'b0000_0001,
        ST_COPY    = 8'b0000_0010,
        ST_RA      = 8'b0000_0100,
        ST_RB      = 8'b0000_1000,
        ST_MUL     = 8'b0001_0000,
        ST_RND     = 8'b0010_0000,
        ST_WA      = 8'b0100_0000,
        ST_WB      = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [LG-1:0]       cnt_reg;
    logic [LG-1:0]       copy_reg;
    logic                cp_vld_reg;
    logic [LG-1:0]       cp_addr_reg;
    logic [SW-1:0]       stage_reg;
    logic [LG-2:0]       bf_reg;
    logic                have_reg;
    logic                pend_reg;
    logic                pend_have_reg;
    logic [LG-1:0]       pend_idx_reg;
    tw_word_t            tw_reg;
    logic                out_vld_reg;
    logic [55:0]         out_data_reg;
    logic                out_user_reg;
    logic                out_last_reg;

    logic                in_xfer;
    logic [LG-1:0]       mask, bf_ext, idx_i, idx_ip;
    logic [LG-2:0]       tw_k;
    logic [SW-1:0]       k_shift;

    logic                in_we;
    logic [IN_WIDTH-1:0] in_rdata;
    logic                wk_we;
    logic [LG-1:0]       wk_waddr, wk_raddr;
    logic [WORK_WIDTH-1:0] wk_wdata, wk_rdata;
    logic [WORK_WIDTH-1:0] top_word, bot_word;
    logic [WORK_WIDTH-1:0] copy_word;
    bfly_ctl_t           bctl;

    // input handshake: one sample in flight per bin fetch
    assign s_axis_tready = (state_reg == ST_COLLECT) && !pend_reg
                           && (!out_vld_reg || m_axis_tready);
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign in_we   = in_xfer;

    // butterfly addressing for the current stage
    assign mask    = (LG'(1) << stage_reg) - LG'(1);
    assign bf_ext  = LG'(bf_reg);
    assign idx_i   = ((bf_ext & ~mask) << 1) | (bf_ext & mask);
    assign idx_ip  = idx_i | (LG'(1) << stage_reg);
    assign k_shift = SW'(LG - 1) - stage_reg;
    assign tw_k    = (LG-1)'((bf_ext & mask) << k_shift);

    // sign-extended copy word, packed {im, re}
    assign copy_word = {W'($signed(in_rdata[IN_WIDTH-1:SAMPLE_BITS])),
                        W'($signed(in_rdata[SAMPLE_BITS-1:0]))};

    // work RAM port muxing
    always_comb
    begin
        wk_we    = cp_vld_reg || (state_reg == ST_WA) || (state_reg == ST_WB);
        wk_waddr = cp_addr_reg;
        wk_wdata = copy_word;
        wk_raddr = cnt_reg;
        case (state_reg)
            ST_WA:
            begin
                wk_waddr = idx_i;
                wk_wdata = top_word;
            end
            ST_WB:
            begin
                wk_waddr = idx_ip;
                wk_wdata = bot_word;
            end
            default:
            begin
                wk_waddr = cp_addr_reg;
                wk_wdata = copy_word;
            end
        endcase
        case (state_reg)
            ST_RA:   wk_raddr = idx_i;
            ST_RB:   wk_raddr = idx_ip;
            default: wk_raddr = cnt_reg;
        endcase
    end

    assign bctl.cap_a = (state_reg == ST_RB);
    assign bctl.mul   = (state_reg == ST_MUL);
    assign bctl.rnd   = (state_reg == ST_RND);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
                if (in_xfer && (cnt_reg == LG'(POINTS - 1)))
                    state_next = ST_COPY;
            ST_COPY:
                if (copy_reg == LG'(POINTS - 1))
                    state_next = ST_RA;
            ST_RA:  state_next = ST_RB;
            ST_RB:  state_next = ST_MUL;
            ST_MUL: state_next = ST_RND;
            ST_RND: state_next = ST_WA;
            ST_WA:  state_next = ST_WB;
            ST_WB:
                if ((bf_reg == (LG-1)'(HALF - 1)) && (stage_reg == SW'(LG - 1)))
                    state_next = ST_COLLECT;
                else
                    state_next = ST_RA;
            default: state_next = ST_COLLECT;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            cnt_reg     <= '0;
            copy_reg    <= '0;
            cp_vld_reg  <= 1'b0;
            stage_reg   <= '0;
            bf_reg      <= '0;
            have_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= in_xfer;
            cp_vld_reg <= (state_reg == ST_COPY);
            if (in_xfer)
                cnt_reg <= cnt_reg + LG'(1);
            if (state_reg == ST_COPY)
                copy_reg <= copy_reg + LG'(1);
            if (state_reg == ST_WB)
            begin
                bf_reg <= bf_reg + (LG-1)'(1);
                if (bf_reg == (LG-1)'(HALF - 1))
                begin
                    if (stage_reg == SW'(LG - 1))
                    begin
                        stage_reg <= '0;
                        have_reg  <= 1'b1;
                    end
                    else
                        stage_reg <= stage_reg + SW'(1);
                end
            end
            if (pend_reg)
                out_vld_reg <= 1'b1;
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cp_addr_reg <= bit_rev(copy_reg);
        if (state_reg == ST_RA)
            tw_reg <= TW_TABLE[tw_k];
        if (in_xfer)
        begin
            pend_have_reg <= have_reg;
            pend_idx_reg  <= cnt_reg;
        end
        if (pend_reg)
        begin
            if (pend_have_reg)
                out_data_reg <= {1'b0, pend_idx_reg,
                                 sat_out(wk_rdata[2*W-1:W]), sat_out(wk_rdata[W-1:0])};
            else
                out_data_reg <= {1'b0, pend_idx_reg, 48'd0};
            out_user_reg <= pend_have_reg;
            out_last_reg <= (pend_idx_reg == LG'(POINTS - 1));
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // sample store, natural order
    r2fft_ram #(
        .WIDTH (IN_WIDTH),
        .DEPTH (POINTS)
    ) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (cnt_reg),
        .wdata (s_axis_tdata[IN_WIDTH-1:0]),
        .raddr (copy_reg),
        .rdata (in_rdata)
    );

    // in-place work store, holds the finished bins between frames
    r2fft_ram #(
        .WIDTH (WORK_WIDTH),
        .DEPTH (POINTS)
    ) u_work_ram (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wdata),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

    r2fft_bfly u_bfly (
        .clk      (clk),
        .ctl      (bctl),
        .rd_data  (wk_rdata),
        .tw       (tw_reg),
        .top_word (top_word),
        .bot_word (bot_word)
    );

endmodule

@@ rtl/core/r2fft_ram.sv @@
// ============================================================================
// r2fft_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module r2fft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/r2fft_bfly.sv @@
// ============================================================================
// r2fft_bfly
// Butterfly datapath: captures the upper operand, multiplies the lower one by
// the twiddle, rounds, and forms sum and difference.
// ============================================================================
module r2fft_bfly (
    input  logic                            clk,
    input  r2fft_pkg::bfly_ctl_t            ctl,
    input  logic [r2fft_pkg::WORK_WIDTH-1:0] rd_data,
    input  r2fft_pkg::tw_word_t             tw,
    output logic [r2fft_pkg::WORK_WIDTH-1:0] top_word,
    output logic [r2fft_pkg::WORK_WIDTH-1:0] bot_word
);
    import r2fft_pkg::*;

    localparam int PW = W + TW_BITS;
    localparam int SUMW = PW + 1;

    logic signed [W-1:0]       a_re_reg, a_im_reg;
    logic signed [PW-1:0]      p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [W-1:0]       t_re_reg, t_im_reg;
    logic signed [W-1:0]       b_re, b_im;
    logic signed [TW_BITS-1:0] w_re, w_im;
    logic signed [SUMW-1:0]    s_re, s_im;
    logic signed [SUMW-1:0]    r_re, r_im;

    assign b_re = rd_data[W-1:0];
    assign b_im = rd_data[2*W-1:W];
    assign w_re = tw[TW_BITS-1:0];
    assign w_im = tw[2*TW_BITS-1:TW_BITS];

    // products, then rounding half up by floor shift
    assign s_re = SUMW'(p_rr_reg) - SUMW'(p_ii_reg);
    assign s_im = SUMW'(p_ri_reg) + SUMW'(p_ir_reg);
    assign r_re = (s_re + SUMW'(1 << (TW_FRAC - 1))) >>> TW_FRAC;
    assign r_im = (s_im + SUMW'(1 << (TW_FRAC - 1))) >>> TW_FRAC;

    always_ff @(posedge clk)
    begin
        if (ctl.cap_a)
        begin
            a_re_reg <= b_re;
            a_im_reg <= b_im;
        end
        if (ctl.mul)
        begin
            p_rr_reg <= PW'(b_re) * PW'(w_re);
            p_ii_reg <= PW'(b_im) * PW'(w_im);
            p_ri_reg <= PW'(b_re) * PW'(w_im);
            p_ir_reg <= PW'(b_im) * PW'(w_re);
        end
        if (ctl.rnd)
        begin
            t_re_reg <= r_re[W-1:0];
            t_im_reg <= r_im[W-1:0];
        end
    end

    // write-back words, packed {im, re}
    assign top_word = {W'(a_im_reg + t_im_reg), W'(a_re_reg + t_re_reg)};
    assign bot_word = {W'(a_im_reg - t_im_reg), W'(a_re_reg - t_re_reg)};

endmodule

@@ tb/radix2_fft_frame_tb.sv @@
// ============================================================================
// radix2_fft_frame_tb
// Self-checking bench for the streaming 128-point radix-2 frame FFT.
// ============================================================================
// A local fixed-point FFT predicts every bin. Samples stream in through a
// queued driver with random gaps, and bins are drained by a monitor with
// random stalls, including one long hold-off. Each bin is compared field by
// field against the oldest predicted bin.
// ============================================================================
module radix2_fft_frame_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import r2fft_pkg::*;

    localparam int NFFT      = 128;
    localparam int NLOG      = 7;
    localparam int N_RANDOM  = 1950;

    typedef struct packed {
        logic signed [15:0] im;
        logic signed [15:0] re;
    } sample_t;

    typedef struct {
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic [6:0]         index;
        logic               valid;
        logic               last;
    } bin_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    radix2_fft_frame u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // predictor state
    longint  tw_cos [NFFT/2];
    longint  tw_sin [NFFT/2];
    longint  frame_re [NFFT];
    longint  frame_im [NFFT];
    longint  spec_re [NFFT];
    longint  spec_im [NFFT];
    int      fill_count;
    bit      spectrum_ready;

    sample_t samples_pending[$];
    bin_t    bins_expected[$];
    int      mismatches;
    int      bins_seen;
    int      frames_done;
    bit      hold_off;
    bit      hold_used;
    bit      stimulus_done;
    bit      in_fire;

    // Q2.16 cos/sin for a quarter wave, Taylor series in Q30
    task automatic quarter_wave_q16(input int k, output longint c, output longint s);
        logic [63:0] theta;
        logic [63:0] term;
        longint ca;
        longint sa;
        theta = (64'd3373259426 * 64'd2 * 64'(k)) / NFFT;
        term  = 64'd1 << 30;
        ca    = longint'(term);
        sa    = 0;
        for (int n = 1; n <= 26; n++)
        begin
            term = ((term * theta) >> 30) / 64'(n);
            case (n % 4)
                1:       sa += longint'(term);
                2:       ca -= longint'(term);
                3:       sa -= longint'(term);
                default: ca += longint'(term);
            endcase
        end
        if (ca < 0)
            ca = 0;
        if (sa < 0)
            sa = 0;
        c = (ca + 8192) >>> 14;
        s = (sa + 8192) >>> 14;
    endtask

    task automatic build_twiddles();
        longint c;
        longint s;
        for (int k = 0; k < NFFT/2; k++)
        begin
            if (k <= NFFT/4)
            begin
                quarter_wave_q16(k, c, s);
                tw_cos[k] = c;
                tw_sin[k] = -s;
            end
            else
            begin
                quarter_wave_q16(k - NFFT/4, c, s);
                tw_cos[k] = -s;
                tw_sin[k] = -c;
            end
        end
    endtask

    // round half up after dropping 16 fraction bits (arithmetic shift = floor)
    function automatic longint round_q16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    // in-place DIT transform of the collected frame
    task automatic run_fft();
        longint xr [NFFT];
        longint xi [NFFT];
        int     rev;
        int     ip;
        int     stride;
        longint tr;
        longint ti;
        for (int i = 0; i < NFFT; i++)
        begin
            rev = 0;
            for (int b = 0; b < NLOG; b++)
                rev |= ((i >> b) & 1) << (NLOG - 1 - b);
            xr[rev] = frame_re[i];
            xi[rev] = frame_im[i];
        end
        for (int half = 1; half < NFFT; half *= 2)
        begin
            stride = NFFT / (2 * half);
            for (int j = 0; j < half; j++)
            begin
                for (int i = j; i + half < NFFT; i += 2 * half)
                begin
                    ip = i + half;
                    tr = round_q16(xr[ip] * tw_cos[j*stride] - xi[ip] * tw_sin[j*stride]);
                    ti = round_q16(xr[ip] * tw_sin[j*stride] + xi[ip] * tw_cos[j*stride]);
                    xr[ip] = xr[i] - tr;
                    xi[ip] = xi[i] - ti;
                    xr[i]  = xr[i] + tr;
                    xi[i]  = xi[i] + ti;
                end
            end
        end
        for (int i = 0; i < NFFT; i++)
        begin
            spec_re[i] = clamp24(xr[i]);
            spec_im[i] = clamp24(xi[i]);
        end
    endtask

    // one sample in, one bin of the previous frame out
    task automatic predict_bin(input sample_t smp);
        bin_t b;
        b.index = 7'(fill_count);
        b.valid = spectrum_ready;
        b.last  = (fill_count == NFFT - 1);
        b.re    = spectrum_ready ? 24'(spec_re[fill_count]) : '0;
        b.im    = spectrum_ready ? 24'(spec_im[fill_count]) : '0;
        bins_expected.push_back(b);
        frame_re[fill_count] = longint'(smp.re);
        frame_im[fill_count] = longint'(smp.im);
        if (fill_count == NFFT - 1)
        begin
            run_fft();
            spectrum_ready = 1'b1;
            fill_count     = 0;
        end
        else
            fill_count++;
    endtask

    function automatic logic [15:0] rand_part(int mode);
        case (mode)
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'(($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // short idle, sometimes long
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 3)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 99) < 40)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    task automatic queue_frame(input int kind);
        sample_t s;
        for (int i = 0; i < NFFT; i++)
        begin
            case (kind)
                0: s = sample_t'{im: 16'h8000, re: 16'h8000};      // full negative DC
                1: s = sample_t'{im: 16'h7fff, re: 16'h7fff};      // full positive DC
                2: s = (i == 0) ? sample_t'{im: 16'h8000, re: 16'h7fff}
                                : sample_t'(32'd0);                // impulse
                3: s = (i % 2) ? sample_t'{im: 16'h7fff, re: 16'h8000}
                               : sample_t'{im: 16'h8000, re: 16'h7fff};  // Nyquist tone
                default: s = sample_t'{im: rand_part($urandom_range(0, 3)),
                                       re: rand_part($urandom_range(0, 3))};
            endcase
            samples_pending.push_back(s);
        end
    endtask

    // clock and reset
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // stimulus: edge-value frames, then random-content frames
    initial
    begin
        fill_count     = 0;
        spectrum_ready = 1'b0;
        build_twiddles();
        queue_frame(0);
        queue_frame(1);
        queue_frame(2);
        queue_frame(3);
        while (samples_pending.size() + NFFT <= N_RANDOM)
            queue_frame(4);
        // partial frame at the tail
        for (int i = 0; i < 37; i++)
            samples_pending.push_back('{im: 16'($urandom), re: 16'($urandom)});
    end

    // driver: presents pending samples with random gaps
    int drive_gap;
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        drive_gap     = 0;
        stimulus_done = 1'b0;
        in_fire       = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_fire)
            begin
                // hold the offered sample until its transfer
            end
            else if (drive_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                drive_gap     <= drive_gap - 1;
            end
            else if (samples_pending.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= samples_pending[0];
                drive_gap     <= gap_len();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                stimulus_done <= 1'b1;
            end
        end
    end

    // sample transfer: drop from queue and predict
    always @(posedge clk)
    begin
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            predict_bin(samples_pending.pop_front());
    end

    // receiver backpressure, with one long hold-off during the second frame
    int stall_left;
    int hold_count;
    initial
    begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        hold_off      = 1'b0;
        hold_used     = 1'b0;
        hold_count    = 0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (bins_seen == 150 && !hold_off && !hold_used)
            begin
                hold_off      <= 1'b1;
                hold_used     <= 1'b1;
                hold_count    <= 400;
                m_axis_tready <= 1'b0;
            end
            else if (hold_off)
            begin
                hold_count <= hold_count - 1;
                if (hold_count == 1)
                begin
                    hold_off      <= 1'b0;
                    m_axis_tready <= 1'b1;
                end
            end
            else if (stall_left > 0)
            begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= (stall_left == 1);
            end
            else if ((bins_seen / 300) % 2 == 1 || $urandom_range(0, 3) != 0)
                m_axis_tready <= 1'b1;
            else
            begin
                stall_left    <= gap_len();
                m_axis_tready <= 1'b0;
            end
        end
    end

    // monitor: compare each bin with the oldest prediction
    always @(posedge clk)
    begin
        bin_t exp_bin;
        bin_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.re    = m_axis_tdata[23:0];
            got.im    = m_axis_tdata[47:24];
            got.index = m_axis_tdata[54:48];
            got.valid = m_axis_tuser;
            got.last  = m_axis_tlast;
            bins_seen <= bins_seen + 1;
            if (got.last && got.valid)
                frames_done <= frames_done + 1;
            if (bins_expected.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("ERROR: unexpected bin index %0d", got.index);
            end
            else
            begin
                exp_bin = bins_expected.pop_front();
                if (got.re !== exp_bin.re || got.im !== exp_bin.im
                    || got.index !== exp_bin.index || got.valid !== exp_bin.valid
                    || got.last !== exp_bin.last || m_axis_tdata[55] !== 1'b0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"ERROR: bin %0d exp re=%0d im=%0d v=%0b l=%0b,",
                                  " got idx=%0d re=%0d im=%0d v=%0b l=%0b"},
                                 exp_bin.index, exp_bin.re, exp_bin.im, exp_bin.valid,
                                 exp_bin.last, got.index, got.re, got.im, got.valid,
                                 got.last);
                end
            end
        end
    end

    initial
    begin
        mismatches  = 0;
        bins_seen   = 0;
        frames_done = 0;
    end

    // end of run
    initial
    begin
        wait (rst_n);
        wait (stimulus_done && samples_pending.size() == 0 && bins_expected.size() == 0);
        repeat (50) @(posedge clk);
        $display("Streamed %0d bins; %0d transformed frames checked, incl. DC, impulse,",
                 bins_seen, frames_done);
        $display("Nyquist and full-scale frames, with random gaps and a long output stall.");
        if (mismatches == 0 && bins_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog: 15 full frames and a partial one, plus gaps and stalls, taken many times over
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
